@@ hdl/isort_pkg.sv @@
// Shared types and constants for the insertion sorter.
package isort_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } sorter_state_t;

endpackage

@@ hdl/isort_cell.sv @@
// One slot of the sorting chain: compare with the new value, shift right on insert,
// shift left on drain.
module isort_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  isort_pkg::cell_ctrl_t ctrl,
    input  isort_pkg::data_t    new_value,
    input  logic                left_valid,
    input  isort_pkg::data_t    left_value,
    input  logic                left_gt,
    input  logic                right_valid,
    input  isort_pkg::data_t    right_value,
    output logic                slot_valid,
    output isort_pkg::data_t    slot_value,
    output logic                slot_gt
);

    logic             valid_reg;
    logic             valid_next;
    isort_pkg::data_t value_reg;
    isort_pkg::data_t value_next;

    // an empty slot acts as larger than anything
    assign slot_gt    = !valid_reg || (value_reg > new_value);
    assign slot_valid = valid_reg;
    assign slot_value = value_reg;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        priority if (ctrl.drain) begin
            valid_next = right_valid;
            value_next = right_value;
        end else if (ctrl.insert && slot_gt) begin
            if (left_gt) begin
                valid_next = left_valid;
                value_next = left_value;
            end else begin
                valid_next = 1'b1;
                value_next = new_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

endmodule

@@ hdl/insertion_sorter.sv @@
// Top level of the streaming stable insertion sorter built from a chain of cells.
//
// Input channel s_*: one signed 32-bit value per transfer, s_tlast marks the
// final value of a set. While filling, one value is taken every cycle; all cells
// compare it with their contents in parallel and the larger entries move one
// cell to the right. Equal values keep arrival order.
// Values arriving while all MAX_ITEMS cells are full are dropped and flagged.
// After the transfer with s_tlast, the state register moves to drain and the set
// drains from cell 0 through the output register, one result per cycle while
// the receiver accepts: N results for a set of N held values, m_tlast on the
// last one, m_tuser set on every result of a set that lost values. s_tready is
// low during the drain. The output register lets the next set start filling
// while the final result still waits. When the receiver stalls, the result
// holds and the drain pauses.
// Reset (aresetn low, synchronous) empties all cells, clears the overflow mark
// and the output valid; the block leaves reset in the fill state, ready for input.
module insertion_sorter #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // end_of_set
    output logic [0:0]  m_tuser    // [0] overflowed
);

    isort_pkg::sorter_state_t state_reg;
    isort_pkg::sorter_state_t state_next;

    logic                 overflow_reg;
    logic                 overflow_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    isort_pkg::data_t     out_value_reg;
    logic                 out_last_reg;
    logic                 out_ovf_reg;

    logic [MAX_ITEMS-1:0] cell_valid;
    logic [MAX_ITEMS-1:0] cell_gt;
    isort_pkg::data_t     cell_value [MAX_ITEMS];

    isort_pkg::cell_ctrl_t ctrl;
    isort_pkg::data_t      new_value;
    logic                  in_xfer;
    logic                  store_full;
    logic                  load_out;
    logic                  final_load;

    assign new_value  = isort_pkg::data_t'(s_tdata);
    assign store_full = cell_valid[MAX_ITEMS-1];
    assign in_xfer    = s_tvalid && s_tready;
    assign final_load = load_out && !cell_valid[1];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            isort_pkg::ST_FILL: begin
                if (in_xfer && s_tlast) begin
                    state_next = isort_pkg::ST_DRAIN;
                end
            end
            isort_pkg::ST_DRAIN: begin
                if (final_load) begin
                    state_next = isort_pkg::ST_FILL;
                end
            end
            default: state_next = isort_pkg::ST_FILL;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            isort_pkg::ST_FILL: begin
                s_tready = 1'b1;
            end
            isort_pkg::ST_DRAIN: begin
                load_out = !out_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        ctrl.insert = in_xfer && !store_full;
        ctrl.drain  = load_out;
    end

    always_comb begin
        overflow_next = overflow_reg;
        if (in_xfer && store_full) begin
            overflow_next = 1'b1;
        end else if (final_load) begin
            overflow_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= isort_pkg::ST_FILL;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
        if (load_out) begin
            out_value_reg <= cell_value[0];
            out_last_reg  <= !cell_valid[1];
            out_ovf_reg   <= overflow_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
            logic             lv;
            logic             lg;
            logic             rv;
            isort_pkg::data_t lval;
            isort_pkg::data_t rval;
            if (i == 0) begin : g_first
                assign lv   = 1'b0;
                assign lg   = 1'b0;
                assign lval = new_value;
            end else begin : g_mid_l
                assign lv   = cell_valid[i-1];
                assign lg   = cell_gt[i-1];
                assign lval = cell_value[i-1];
            end
            if (i == MAX_ITEMS - 1) begin : g_end
                assign rv   = 1'b0;
                assign rval = cell_value[i];
            end else begin : g_mid_r
                assign rv   = cell_valid[i+1];
                assign rval = cell_value[i+1];
            end
            isort_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .new_value   (new_value),
                .left_valid  (lv),
                .left_value  (lval),
                .left_gt     (lg),
                .right_valid (rv),
                .right_value (rval),
                .slot_valid  (cell_valid[i]),
                .slot_value  (cell_value[i]),
                .slot_gt     (cell_gt[i])
            );
        end
    endgenerate

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = 32'(out_value_reg);
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule

@@ sim/tb_insertion_sorter.sv @@
// Self-checking testbench for the streaming stable insertion sorter.
module tb_insertion_sorter;
    timeunit 1ns;
    timeprecision 1ps;

    typedef isort_pkg::data_t data_t;

    localparam int unsigned SORT_DEPTH  = 64;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam data_t       VALUE_MIN   = 32'sh8000_0000;
    localparam data_t       VALUE_MAX   = 32'sh7FFF_FFFF;

    typedef struct {
        data_t value;
        bit    end_mark;
        bit    lost;
    } sorted_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [31:0] value
    logic        s_tlast = 1'b0;   // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] sorted_value
    logic        m_tlast;          // end_of_set
    logic [0:0]  m_tuser;          // [0] overflowed

    data_t          held_values[$];
    bit             values_lost;
    sorted_result_t pending_sorted[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    insertion_sorter #(
        .MAX_ITEMS(SORT_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic void absorb_value(input data_t v, input bit last);
        int unsigned pos;
        int unsigned n;
        if (held_values.size() < SORT_DEPTH) begin
            pos = held_values.size();
            while (pos > 0 && held_values[pos-1] > v) pos--;
            held_values.insert(pos, v);
        end else begin
            values_lost = 1'b1;
        end
        if (last) begin
            n = held_values.size();
            for (int unsigned k = 0; k < n; k++) begin
                pending_sorted.push_back('{held_values[k], k + 1 == n, values_lost});
            end
            held_values.delete();
            values_lost = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic send_value(input data_t v, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_value(v, last);
    endtask

    task automatic send_set(input data_t vals[$]);
        foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
    endtask

    function automatic data_t random_value();
        case ($urandom_range(3))
            0: return $urandom_range(8) - 4;
            1: begin
                case ($urandom_range(3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic test_single_value_sets();
        send_set('{VALUE_MIN});
        send_set('{VALUE_MAX});
    endtask

    task automatic test_field_extremes();
        send_set('{VALUE_MAX, 0, -1, VALUE_MIN, 1, VALUE_MAX - 1, VALUE_MIN + 1});
    endtask

    task automatic test_equal_values();
        send_set('{5, 5, -5, 5, -5});
    endtask

    task automatic test_ordered_inputs();
        send_set('{40, 30, -20, -30});
        send_set('{-30, -20, 30, 40});
    endtask

    task automatic test_store_overflow();
        data_t vals[$];
        for (int i = 0; i < SORT_DEPTH + 1; i++) vals.push_back(random_value());
        send_set(vals);
    endtask

    task automatic test_random_sets(input int unsigned item_count);
        data_t       vals[$];
        int unsigned sent;
        int unsigned set_size;
        sent = 0;
        while (sent < item_count) begin
            set_size = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            vals.delete();
            repeat (set_size) vals.push_back(random_value());
            send_set(vals);
            sent += set_size;
        end
    endtask

    always @(posedge aclk) begin
        sorted_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sorted.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", $signed(m_tdata)));
            end else begin
                want = pending_sorted.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("sorted_value %0d, want %0d",
                                              $signed(m_tdata), want.value));
                if (m_tlast !== want.end_mark)
                    report_mismatch($sformatf("end_of_set %b, want %b for %0d",
                                              m_tlast, want.end_mark, want.value));
                if (m_tuser[0] !== want.lost)
                    report_mismatch($sformatf("overflowed %b, want %b for %0d",
                                              m_tuser[0], want.lost, want.value));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        values_lost  = 1'b0;
        set_idling(0, 0);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_idling(33, 68);
        test_single_value_sets();
        test_field_extremes();
        test_equal_values();
        test_ordered_inputs();
        test_random_sets(6);

        set_idling(68, 33);
        test_store_overflow();
        test_random_sets(6);

        set_idling(0, 0);
        test_random_sets(6);

        s_tvalid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
